[hdl/blid_pkg.sv]
// ----------------------------------------------------------------------------
// blid_pkg
// Shared constants and types for the bounded list insert/delete core.
// ----------------------------------------------------------------------------
package blid_pkg;

	localparam int DEF_CAPACITY = 32;
	localparam int DATA_W       = 32;
	localparam int FUNC_W       = 2;
	localparam int POS_W        = 7;

	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DELETE     = 2'd2;

	// flags that travel with one result item
	typedef struct packed {
		logic last;
		logic empty_res;
		logic dropped;
	} emit_flags_t;

endpackage

[hdl/blid_ram.sv]
// ----------------------------------------------------------------------------
// blid_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module blid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/blid_out.sv]
// ----------------------------------------------------------------------------
// blid_out
// Output register for result items, decouples the sequencer from res_stall.
// ----------------------------------------------------------------------------
module blid_out import blid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic signed [DATA_W-1:0] load_element,
	input  emit_flags_t              load_flags,
	output logic                     free,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [DATA_W-1:0] element,
	output logic                     last,
	output logic                     empty_res,
	output logic                     dropped
);

	logic                     valid_q;
	logic signed [DATA_W-1:0] element_q;
	emit_flags_t              flags_q;

	assign free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			element_q <= load_element;
			flags_q   <= load_flags;
		end
	end

	assign res_valid = valid_q;
	assign element   = element_q;
	assign last      = flags_q.last;
	assign empty_res = flags_q.empty_res;
	assign dropped   = flags_q.dropped;

endmodule

[hdl/blid_seq.sv]
// ----------------------------------------------------------------------------
// blid_seq
// Sequencer: applies a request to the list store, shifts entries on delete
// and walks the list front to back to emit it.
// ----------------------------------------------------------------------------
module blid_seq import blid_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int PW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [POS_W-1:0]  position,
	output logic                     ram_we,
	output logic [PW-1:0]            ram_waddr,
	output logic [DATA_W-1:0]        ram_wdata,
	output logic [PW-1:0]            ram_raddr,
	input  logic [DATA_W-1:0]        ram_rdata,
	input  logic                     out_free,
	output logic                     out_load,
	output logic signed [DATA_W-1:0] out_element,
	output emit_flags_t              out_flags
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SHIFT   = 2'd1;
	localparam logic [1:0] ST_EMIT_RD = 2'd2;
	localparam logic [1:0] ST_EMIT_WR = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] front_q;
	logic [CW-1:0] idx_q;
	logic          drop_q;
	logic          shift_v_s1;
	logic [PW-1:0] shift_addr_s1;

	logic          req_acc;
	logic          full;
	logic          del_ok;
	logic [PW-1:0] front_dec;
	logic [CW-1:0] idx_inc;
	logic          list_empty;
	logic          emit_last;

	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
		input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(i);
		if (s >= (CW+1)'(CAPACITY)) begin
			s = s - (CW+1)'(CAPACITY);
		end
		return s[PW-1:0];
	endfunction

	assign req_stall  = (state_q != ST_IDLE);
	assign req_acc    = req_valid && (state_q == ST_IDLE);
	assign full       = (count_q == CW'(CAPACITY));
	assign del_ok     = !position[POS_W-1] && (7'(position[POS_W-2:0]) < 7'(count_q));
	assign front_dec  = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - PW'(1);
	assign idx_inc    = idx_q + CW'(1);
	assign list_empty = (count_q == '0);
	assign emit_last  = list_empty || (idx_inc == count_q);

	// store write port: inserts on accept, shifted entries during delete
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_of(front_q, count_q);
		ram_wdata = value;
		if (req_acc && !full && func == FUNC_PUSH_FRONT) begin
			ram_we    = 1'b1;
			ram_waddr = front_dec;
		end else if (req_acc && !full && func == FUNC_PUSH_BACK) begin
			ram_we    = 1'b1;
		end else if (shift_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = shift_addr_s1;
			ram_wdata = ram_rdata;
		end
	end

	assign ram_raddr = (state_q == ST_SHIFT) ? slot_of(front_q, idx_inc)
	                                         : slot_of(front_q, idx_q);

	assign out_load        = (state_q == ST_EMIT_WR) && out_free;
	assign out_element     = list_empty ? '0 : ram_rdata;
	assign out_flags.last      = emit_last;
	assign out_flags.empty_res = list_empty;
	assign out_flags.dropped   = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			front_q       <= '0;
			idx_q         <= '0;
			drop_q        <= 1'b0;
			shift_v_s1    <= 1'b0;
			shift_addr_s1 <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
						drop_q  <= 1'b1;
						case (func)
							FUNC_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_dec;
									count_q <= count_q + CW'(1);
									drop_q  <= 1'b0;
								end
							end
							FUNC_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
									drop_q  <= 1'b0;
								end
							end
							FUNC_DELETE: begin
								if (del_ok) begin
									count_q <= count_q - CW'(1);
									idx_q   <= CW'(position[POS_W-2:0]);
									drop_q  <= 1'b0;
									state_q <= ST_SHIFT;
								end
							end
							default: begin
								drop_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					if (idx_q < count_q) begin
						shift_v_s1    <= 1'b1;
						shift_addr_s1 <= slot_of(front_q, idx_q);
						idx_q         <= idx_inc;
					end else begin
						shift_v_s1 <= 1'b0;
						idx_q      <= '0;
						state_q    <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(front_q) < CAPACITY)
		else $error("front pointer out of range");

	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> !ram_we)
		else $error("store written while emitting");

	a_shift_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		shift_v_s1 |-> state_q == ST_SHIFT)
		else $error("shift write pending outside shift state");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && !full && func == FUNC_PUSH_BACK) |=>
		count_q == $past(count_q) + CW'(1))
		else $error("count not advanced on insert");
`endif

endmodule

[hdl/bounded_list_insert_delete_core.sv]
// an accepted request runs ST_SHIFT on delete, then ST_EMIT_RD and ST_EMIT_WR, to load its first result
// ST_EMIT_WR waits for a free output register; new requests stall until the last result loads
// delete at position P of N entries first moves the N - P - 1 entries after P one slot toward the front
// one read per cycle drives the delete shift; each result is read in ST_EMIT_RD, loaded in ST_EMIT_WR
// reset: asynchronous, clears entry count, front pointer and sequencer; store is not cleared
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_core
// Ordered list of signed values held in a circular RAM, with front/back
// insert and positional delete; emits the whole list after every request.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_core import blid_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [POS_W-1:0]  position,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic signed [DATA_W-1:0] element,
	output logic                     last,
	output logic                     empty_res,
	output logic                     dropped
);

	localparam int PW = $clog2(CAPACITY);

	logic                     ram_we;
	logic [PW-1:0]            ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [PW-1:0]            ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic                     out_free;
	logic                     out_load;
	logic signed [DATA_W-1:0] out_element;
	emit_flags_t              out_flags;

	blid_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	blid_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.value      (value),
		.position   (position),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_free   (out_free),
		.out_load   (out_load),
		.out_element(out_element),
		.out_flags  (out_flags)
	);

	blid_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.load_element(out_element),
		.load_flags  (out_flags),
		.free        (out_free),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.element     (element),
		.last        (last),
		.empty_res   (empty_res),
		.dropped     (dropped)
	);

endmodule

[test/tb_bounded_list_insert_delete_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_list_insert_delete_core
// Drives front/back inserts, positional deletes and unused codes into the
// list core and checks every emitted list against a queue-based model of
// the list. A short directed table opens the run, then random sequences
// that fill, drain and mix, under several idling patterns and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bounded_list_insert_delete_core;
	import blid_pkg::*;

	localparam int CAPACITY     = DEF_CAPACITY;
	localparam int HOLD_CYCLES  = 300;
	localparam int WATCHDOG_MAX = 4000;
	localparam int TAIL_CYCLES  = 4 * CAPACITY + 20;
	localparam int BURST_ITEMS  = 52;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_e;
	typedef enum logic [1:0] {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED} seq_kind_e;

	typedef struct packed {
		logic signed [DATA_W-1:0] element;
		logic                     last;
		logic                     empty_res;
		logic                     dropped;
	} listing_t;

	typedef struct packed {
		logic [FUNC_W-1:0]        f;
		logic signed [DATA_W-1:0] v;
		logic signed [POS_W-1:0]  p;
		logic                     typed;
		logic signed [DATA_W-1:0] e_element;
		logic                     e_last;
		logic                     e_empty;
		logic                     e_dropped;
	} dir_row_t;

	localparam int DIR_ROWS = 17;

	// typed rows leave a single result: empty list or one entry
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{FUNC_DELETE,     32'sh0,        7'sd0,   1'b1, 32'sh0,        1'b1, 1'b1, 1'b1},
		'{FUNC_UNUSED,     32'sh5a5a5a5a, 7'sd0,   1'b1, 32'sh0,        1'b1, 1'b1, 1'b1},
		'{FUNC_PUSH_FRONT, 32'sh7fffffff, 7'sh55,  1'b1, 32'sh7fffffff, 1'b1, 1'b0, 1'b0},
		'{FUNC_DELETE,     32'sh0,        7'sh7f,  1'b1, 32'sh7fffffff, 1'b1, 1'b0, 1'b1},
		'{FUNC_DELETE,     32'sh0,        7'sd1,   1'b1, 32'sh7fffffff, 1'b1, 1'b0, 1'b1},
		'{FUNC_DELETE,     32'sh0,        7'sh40,  1'b1, 32'sh7fffffff, 1'b1, 1'b0, 1'b1},
		'{FUNC_DELETE,     32'sh0,        7'sd63,  1'b1, 32'sh7fffffff, 1'b1, 1'b0, 1'b1},
		'{FUNC_DELETE,     32'shffffffff, 7'sd0,   1'b1, 32'sh0,        1'b1, 1'b1, 1'b0},
		'{FUNC_PUSH_BACK,  32'sh80000000, 7'sh7f,  1'b1, 32'sh80000000, 1'b1, 1'b0, 1'b0},
		'{FUNC_PUSH_FRONT, 32'sh0,        7'sd0,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_PUSH_BACK,  32'shffffffff, 7'sd0,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_UNUSED,     32'sh0,        7'sd1,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_DELETE,     32'sh0,        7'sd1,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_PUSH_FRONT, 32'sh12345678, 7'sd0,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_DELETE,     32'sh0,        7'sd2,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_DELETE,     32'sh0,        7'sd0,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0},
		'{FUNC_DELETE,     32'sh0,        7'sd5,   1'b0, 32'sh0,        1'b0, 1'b0, 1'b0}
	};

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [FUNC_W-1:0]        func      = FUNC_PUSH_FRONT;
	logic signed [DATA_W-1:0] value     = '0;
	logic signed [POS_W-1:0]  position  = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic signed [DATA_W-1:0] element;
	logic                     last;
	logic                     empty_res;
	logic                     dropped;

	logic signed [DATA_W-1:0] list_q [$];
	listing_t                 listing_q [$];
	listing_t                 want;
	int                       err_cnt   = 0;
	int                       idle_cnt  = 0;
	int                       tx_pct    = 0;
	int                       rx_pct    = 0;
	logic                     hold_req  = 1'b0;
	logic                     hold_ack  = 1'b0;
	int                       hold_left = 0;

	bounded_list_insert_delete_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.value     (value),
		.position  (position),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.element   (element),
		.last      (last),
		.empty_res (empty_res),
		.dropped   (dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// list model: returns 1 when the request leaves the list unchanged
	function automatic bit apply_request(input logic [FUNC_W-1:0] f,
			input logic signed [DATA_W-1:0] v, input logic signed [POS_W-1:0] p);
		bit drop;
		drop = 1'b0;
		case (f)
			FUNC_PUSH_FRONT: begin
				if (list_q.size() >= CAPACITY)
					drop = 1'b1;
				else
					list_q.push_front(v);
			end
			FUNC_PUSH_BACK: begin
				if (list_q.size() >= CAPACITY)
					drop = 1'b1;
				else
					list_q.push_back(v);
			end
			FUNC_DELETE: begin
				if (p[POS_W-1] || $unsigned(p) >= list_q.size())
					drop = 1'b1;
				else
					list_q.delete(int'($unsigned(p)));
			end
			default: drop = 1'b1;
		endcase
		return drop;
	endfunction

	function automatic void queue_listing(input bit drop);
		listing_t r;
		r.empty_res = 1'b0;
		r.dropped   = drop;
		if (list_q.size() == 0) begin
			r.element   = '0;
			r.last      = 1'b1;
			r.empty_res = 1'b1;
			listing_q.push_back(r);
		end else begin
			for (int i = 0; i < list_q.size(); i++) begin
				r.element = list_q[i];
				r.last    = (i == list_q.size() - 1);
				listing_q.push_back(r);
			end
		end
	endfunction

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
			input logic signed [POS_W-1:0] p, input bit typed, input listing_t typed_res);
		int gap;
		bit drop;
		gap = 0;
		while ($urandom_range(99) < tx_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		value     <= v;
		position  <= p;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		drop = apply_request(f, v, p);
		if (typed)
			listing_q.push_back(typed_res);
		else
			queue_listing(drop);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (listing_q.size() != 0);
	endtask

	task automatic set_idling(input idling_e mode);
		case (mode)
			IDLE_NONE: begin
				tx_pct = 0;
				rx_pct <= 0;
			end
			IDLE_SENDER: begin
				tx_pct = 74;
				rx_pct <= 0;
			end
			IDLE_RECEIVER: begin
				tx_pct = 0;
				rx_pct <= 74;
			end
			default: begin
				tx_pct = 15;
				rx_pct <= 15;
			end
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(39))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return 32'shffffffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_burst(input int n);
		seq_kind_e kind;
		int roll, ins_pct, sz;
		logic [FUNC_W-1:0] f;
		logic signed [POS_W-1:0] p;
		listing_t none;
		none = '0;
		kind = SEQ_MIXED;
		for (int k = 0; k < n; k++) begin
			if (k % 12 == 0)
				kind = seq_kind_e'($urandom_range(2));
			ins_pct = (kind == SEQ_FILL) ? 85 : (kind == SEQ_DRAIN) ? 15 : 50;
			sz = list_q.size();
			roll = $urandom_range(99);
			p = POS_W'($urandom_range(127));
			if (roll < 10) begin
				// broken requests: unused code, negative or past-the-end position
				case ($urandom_range(2))
					0: f = FUNC_UNUSED;
					1: begin
						f = FUNC_DELETE;
						p = POS_W'($urandom_range(127, 64));
					end
					default: begin
						f = FUNC_DELETE;
						p = POS_W'($urandom_range(63, sz));
					end
				endcase
			end else if ($urandom_range(99) < ins_pct) begin
				f = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
			end else begin
				f = FUNC_DELETE;
				p = (sz == 0) ? POS_W'($urandom_range(63)) : POS_W'($urandom_range(sz - 1));
			end
			send_item(f, rand_value(), p, 1'b0, none);
		end
	endtask

	// receiver: random stall, or a counted hold-off when requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (listing_q.size() == 0) begin
				$display("%0t: unexpected item: element %0d last %0b empty %0b dropped %0b",
					$time, element, last, empty_res, dropped);
				err_cnt++;
			end else begin
				want = listing_q.pop_front();
				if (element !== want.element) begin
					$display("%0t: element mismatch: expected %0d, got %0d",
						$time, want.element, element);
					err_cnt++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
					err_cnt++;
				end
				if (empty_res !== want.empty_res) begin
					$display("%0t: empty_res mismatch: expected %0b, got %0b",
						$time, want.empty_res, empty_res);
					err_cnt++;
				end
				if (dropped !== want.dropped) begin
					$display("%0t: dropped mismatch: expected %0b, got %0b",
						$time, want.dropped, dropped);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_MAX) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cnt);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		listing_t r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(IDLE_NONE);
		for (int i = 0; i < DIR_ROWS; i++) begin
			r.element   = dir_rows[i].e_element;
			r.last      = dir_rows[i].e_last;
			r.empty_res = dir_rows[i].e_empty;
			r.dropped   = dir_rows[i].e_dropped;
			send_item(dir_rows[i].f, dir_rows[i].v, dir_rows[i].p, dir_rows[i].typed, r);
		end
		wait_drained();
		for (int ph = 0; ph < 8; ph++) begin
			set_idling(idling_e'(ph % 4));
			run_burst(BURST_ITEMS);
			wait_drained();
		end
		// long receiver hold-off while requests keep coming
		set_idling(IDLE_NONE);
		hold_req <= ~hold_req;
		run_burst(40);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[bounded_list_insert_delete_core.f]
hdl/blid_pkg.sv
hdl/blid_ram.sv
hdl/blid_out.sv
hdl/blid_seq.sv
hdl/bounded_list_insert_delete_core.sv
test/tb_bounded_list_insert_delete_core.sv
